### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the deframer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, ignored while in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/wsdf_pkg.sv
// Types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Extended-length and key byte counts, minus one.
    localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

endpackage

### rtl/core/websocket_frame_deframer_core.sv
// WebSocket frame deframer core: byte-wise header parser and payload unmasker.
//
// Input channel: one received stream byte per beat on in_byte (in_valid/in_ready).
// Output channel: one payload beat per payload byte, carrying data_byte (unmasked),
// data_valid, fin_flag, frame_opcode and last_of_frame (out_valid/out_ready).
// Header, extended-length and masking-key bytes produce no output beat. A frame
// with zero payload length gives one beat with data_valid low and last_of_frame high.
// Each result is registered and presented in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle unless the output stalls; the parser state and the output register are
// both updated in the cycle a byte is taken, and the 64-bit length countdown
// is the longest path.
// in_ready is high whenever the output register is empty or being emptied, so a
// stalled receiver holds back the input only once a result is waiting.
// Reset returns the parser to the first header byte and empties the output register.
module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic       fin_flag,
    output logic [3:0] frame_opcode,
    output logic       last_of_frame
);

`include "assert_macros.svh"

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_en_reg, mask_en_next;
    logic [63:0] rem_len_reg, rem_len_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_idx_reg, key_idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic        data_valid_reg, data_valid_next;
    logic        fin_out_reg, fin_out_next;
    logic [3:0]  opcode_out_reg, opcode_out_next;
    logic        last_reg, last_next;

    logic        in_fire;
    logic        emit;
    logic [6:0]  len_code;
    logic [63:0] ext_len;
    logic [63:0] rem_dec;
    logic [31:0] key_shifted;
    logic [7:0]  key_byte;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign len_code    = in_byte[6:0];
    assign ext_len     = {rem_len_reg[55:0], in_byte};
    assign rem_dec     = rem_len_reg - 64'd1;
    assign key_shifted = {mask_key_reg[23:0], in_byte};

    always_comb
    begin
        unique case (key_idx_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HDR0:
                    phase_next = PH_HDR1;
                PH_HDR1:
                begin
                    priority if (len_code == LEN_CODE_EXT16 || len_code == LEN_CODE_EXT64)
                        phase_next = PH_EXTLEN;
                    else if (in_byte[7])
                        phase_next = PH_KEY;
                    else if (len_code == 7'd0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_EXTLEN:
                begin
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        priority if (mask_en_reg)
                            phase_next = PH_KEY;
                        else if (ext_len == 64'd0)
                            phase_next = PH_HDR0;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_KEY:
                begin
                    if (hdr_cnt_reg == 3'd0)
                        phase_next = (rem_len_reg == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (rem_dec == 64'd0)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end
    end

    // Datapath and result
    always_comb
    begin
        fin_next        = fin_reg;
        opcode_next     = opcode_reg;
        mask_en_next    = mask_en_reg;
        rem_len_next    = rem_len_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        mask_key_next   = mask_key_reg;
        key_idx_next    = key_idx_reg;
        emit            = 1'b0;
        data_byte_next  = 8'd0;
        data_valid_next = 1'b0;
        last_next       = 1'b1;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                end
                PH_HDR1:
                begin
                    mask_en_next = in_byte[7];
                    rem_len_next = 64'd0;
                    priority if (len_code == LEN_CODE_EXT16)
                        hdr_cnt_next = EXT16_BYTES_M1;
                    else if (len_code == LEN_CODE_EXT64)
                        hdr_cnt_next = EXT64_BYTES_M1;
                    else
                    begin
                        rem_len_next = {57'd0, len_code};
                        if (in_byte[7])
                        begin
                            hdr_cnt_next  = KEY_BYTES_M1;
                            mask_key_next = 32'd0;
                        end
                        else
                        begin
                            key_idx_next = 2'd0;
                            emit         = (len_code == 7'd0);
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    rem_len_next = ext_len;
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        if (mask_en_reg)
                        begin
                            hdr_cnt_next  = KEY_BYTES_M1;
                            mask_key_next = 32'd0;
                        end
                        else
                        begin
                            key_idx_next = 2'd0;
                            emit         = (ext_len == 64'd0);
                        end
                    end
                    else
                        hdr_cnt_next = hdr_cnt_reg - 3'd1;
                end
                PH_KEY:
                begin
                    mask_key_next = key_shifted;
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        key_idx_next = 2'd0;
                        emit         = (rem_len_reg == 64'd0);
                    end
                    else
                        hdr_cnt_next = hdr_cnt_reg - 3'd1;
                end
                PH_PAYLOAD:
                begin
                    rem_len_next    = rem_dec;
                    key_idx_next    = key_idx_reg + 2'd1;
                    emit            = 1'b1;
                    data_valid_next = 1'b1;
                    data_byte_next  = mask_en_reg ? (in_byte ^ key_byte) : in_byte;
                    last_next       = (rem_dec == 64'd0);
                end
                default:
                begin
                end
            endcase
        end

        // fin/opcode held from the header; they never change in the emitting cycle
        fin_out_next    = fin_reg;
        opcode_out_next = opcode_reg;
        out_valid_next  = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            fin_reg       <= 1'b0;
            opcode_reg    <= 4'd0;
            mask_en_reg   <= 1'b0;
            rem_len_reg   <= 64'd0;
            hdr_cnt_reg   <= 3'd0;
            mask_key_reg  <= 32'd0;
            key_idx_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_en_reg   <= mask_en_next;
            rem_len_reg   <= rem_len_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            mask_key_reg  <= mask_key_next;
            key_idx_reg   <= key_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_byte_reg  <= data_byte_next;
            data_valid_reg <= data_valid_next;
            fin_out_reg    <= fin_out_next;
            opcode_out_reg <= opcode_out_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_byte_reg;
    assign data_valid    = data_valid_reg;
    assign fin_flag      = fin_out_reg;
    assign frame_opcode  = opcode_out_reg;
    assign last_of_frame = last_reg;

    `ASSERT_SAME(a_ready_when_empty, !out_valid_reg, in_ready)
    `ASSERT_NEXT(a_payload_gives_beat, in_fire && phase_reg == PH_PAYLOAD, out_valid_reg && data_valid_reg)
    `ASSERT_SAME(a_empty_frame_beat, out_valid_reg && !data_valid_reg, last_reg && data_byte_reg == 8'd0)
    `ASSERT_SAME(a_key_needs_mask, phase_reg == PH_KEY, mask_en_reg)
    `ASSERT_SAME(a_payload_nonzero, phase_reg == PH_PAYLOAD, rem_len_reg != 64'd0)

endmodule

### test/tb_top.sv
// Self-checking testbench for the WebSocket frame deframer core: byte stream in, payload beats out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wsdf_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 5;

    // How a frame's payload length is encoded in the header
    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       fin;
        logic [3:0] opcode;
        logic       last;
    } beat_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic       last_of_frame;

    // Parser state of the predictor
    phase_t      ph      = PH_HDR0;
    logic        fin_q   = 1'b0;
    logic [3:0]  opc_q   = 4'h0;
    logic        msk_q   = 1'b0;
    logic [63:0] rem_len = '0;
    logic [2:0]  hdr_cnt = '0;
    logic [31:0] key_q   = '0;
    logic [1:0]  kidx    = '0;

    beat_t expected_beats[$];
    beat_t got_b;
    beat_t want_b;
    int    err_cnt  = 0;
    int    sent_cnt = 0;
    bit    idle_en  = 1'b1;
    bit    hold_req = 1'b0;

    websocket_frame_deframer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .fin_flag      (fin_flag),
        .frame_opcode  (frame_opcode),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Appends one expected beat at the tail of the queue
    task automatic queue_beat(input beat_t b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic header_done();
        kidx = '0;
        if (rem_len == 0)
        begin
            ph = PH_HDR0;
            queue_beat(beat_t'{data: 8'h00, valid: 1'b0, fin: fin_q,
                               opcode: opc_q, last: 1'b1});
        end
        else
            ph = PH_PAYLOAD;
    endtask

    task automatic length_done();
        if (msk_q)
        begin
            ph      = PH_KEY;
            hdr_cnt = KEY_BYTES_M1;
            key_q   = '0;
        end
        else
            header_done();
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] d;
        case (ph)
            PH_HDR0:
            begin
                fin_q = b[7];
                opc_q = b[3:0];
                ph    = PH_HDR1;
            end
            PH_HDR1:
            begin
                msk_q   = b[7];
                rem_len = '0;
                if (b[6:0] == LEN_CODE_EXT16)
                begin
                    ph      = PH_EXTLEN;
                    hdr_cnt = EXT16_BYTES_M1;
                end
                else if (b[6:0] == LEN_CODE_EXT64)
                begin
                    ph      = PH_EXTLEN;
                    hdr_cnt = EXT64_BYTES_M1;
                end
                else
                begin
                    rem_len = 64'(b[6:0]);
                    length_done();
                end
            end
            PH_EXTLEN:
            begin
                rem_len = {rem_len[55:0], b};
                if (hdr_cnt == 0)
                    length_done();
                else
                    hdr_cnt--;
            end
            PH_KEY:
            begin
                key_q = {key_q[23:0], b};
                if (hdr_cnt == 0)
                    header_done();
                else
                    hdr_cnt--;
            end
            PH_PAYLOAD:
            begin
                d = msk_q ? (b ^ key_q[8*(3-kidx) +: 8]) : b;
                kidx++;
                rem_len--;
                queue_beat(beat_t'{data: d, valid: 1'b1, fin: fin_q,
                                   opcode: opc_q, last: (rem_len == 0)});
                if (rem_len == 0)
                    ph = PH_HDR0;
            end
            default:
                ph = PH_HDR0;
        endcase
    endtask

    // ---------------------------------------------------------------- channels

    task automatic send_byte(input logic [7:0] b);
        while (idle_en && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        deframe_byte(b);
        sent_cnt++;
    endtask

    // Header, optional extended length and key, then n_payload random bytes
    task automatic send_frame(input logic [7:0] hdr0, input bit masked,
                              input len_mode_t mode, input logic [63:0] len,
                              input int n_payload);
        logic [6:0] code;
        code = (mode == LEN_EXT16) ? LEN_CODE_EXT16 :
               (mode == LEN_EXT64) ? LEN_CODE_EXT64 : len[6:0];
        send_byte(hdr0);
        send_byte({masked, code});
        if (mode == LEN_EXT16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (mode == LEN_EXT64)
            for (int i = 7; i >= 0; i--)
                send_byte(len[8*i +: 8]);
        if (masked)
            repeat (4) send_byte(8'($urandom_range(255)));
        repeat (n_payload) send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= !(idle_en && $urandom_range(99) < 28);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_b = '{data_byte, data_valid, fin_flag, frame_opcode, last_of_frame};
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: data_byte %0h last_of_frame %0b",
                       data_byte, last_of_frame);
                err_cnt++;
            end
            else
            begin
                want_b = expected_beats.pop_front();
                check_field("data_byte", want_b.data, got_b.data);
                check_field("data_valid", want_b.valid, got_b.valid);
                check_field("fin_flag", want_b.fin, got_b.fin);
                check_field("frame_opcode", want_b.opcode, got_b.opcode);
                check_field("last_of_frame", want_b.last, got_b.last);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_empty_frames();
        // zero length, unmasked then masked (empty beat only after the key)
        send_byte(8'h81);
        send_byte(8'h00);
        send_byte(8'h09);
        send_byte(8'h80);
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);
    endtask

    task automatic test_short_frames();
        // fin clear, opcode 0xF, payload extremes, no mask
        send_byte(8'h0F);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // RSV bits set, masked, key wraps past four bytes
        send_byte(8'hF2);
        send_byte(8'h85);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        repeat (5) send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_ext_lengths();
        // non-minimal 16-bit length of zero, then 64-bit length of one
        send_byte(8'h81);
        send_byte({1'b0, LEN_CODE_EXT16});
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(8'h82, 1'b1, LEN_EXT64, 64'd1, 1);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_frame(8'h82, 1'b1, LEN_SHORT, 64'd40, 40);
        while (hold_req) @(posedge clk);
    endtask

    task automatic test_random_frames();
        int        start_cnt;
        int        r;
        len_mode_t mode;
        int        len;
        start_cnt = sent_cnt;
        while (sent_cnt - start_cnt < RANDOM_ITEMS)
        begin
            // a stretch in the middle runs with no idling on either side
            idle_en = !((sent_cnt - start_cnt) > 300 && (sent_cnt - start_cnt) < 500);
            r = $urandom_range(99);
            if (r < 70)
            begin
                mode = LEN_SHORT;
                len  = ($urandom_range(19) == 0) ? 125 :
                       ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12);
            end
            else if (r < 85)
            begin
                mode = LEN_EXT16;
                len  = ($urandom_range(4) == 0) ? $urandom_range(300) : $urandom_range(20);
            end
            else
            begin
                mode = LEN_EXT64;
                len  = $urandom_range(30);
            end
            send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), mode, 64'(len), len);
        end
        idle_en = 1'b1;
    endtask

    task automatic test_huge_length();
        // full-scale 64-bit length: counts down without ever reaching the end
        send_frame(8'h82, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 30);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_frames();
        test_short_frames();
        test_ext_lengths();
        test_backpressure();
        test_random_frames();
        test_huge_length();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
